// ===== hdl/hidctl_pkg.sv =====
`timescale 1ns / 1ps

package hidctl_pkg;

    // packet and string limits of this keyboard
    localparam int unsigned MAX_PACKET   = 64;
    localparam int unsigned STRING_COUNT = 4;
    localparam int unsigned REPORT_BYTES = 8;

    localparam logic [15:0] MAX_PACKET_W   = 16'(MAX_PACKET);
    localparam logic [6:0]  MAX_PACKET_X   = 7'(MAX_PACKET);
    localparam logic [15:0] REPORT_BYTES_W = 16'(REPORT_BYTES);

    // event kinds on the input channel
    localparam logic [1:0] EV_SETUP     = 2'd0;
    localparam logic [1:0] EV_IN_DONE   = 2'd1;
    localparam logic [1:0] EV_OUT_DONE  = 2'd2;
    localparam logic [1:0] EV_BUS_RESET = 2'd3;

    // bmRequestType without the direction bit
    localparam logic [6:0] RT_STD_DEVICE  = 7'h00;
    localparam logic [6:0] RT_STD_IFACE   = 7'h01;
    localparam logic [6:0] RT_CLASS_IFACE = 7'h21;

    // standard requests
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    // hid class requests
    localparam logic [7:0] HID_GET_REPORT   = 8'd1;
    localparam logic [7:0] HID_GET_IDLE     = 8'd2;
    localparam logic [7:0] HID_GET_PROTOCOL = 8'd3;
    localparam logic [7:0] HID_SET_REPORT   = 8'd9;
    localparam logic [7:0] HID_SET_IDLE     = 8'd10;
    localparam logic [7:0] HID_SET_PROTOCOL = 8'd11;

    // descriptor selectors in wValue
    localparam logic [15:0] DESC_DEVICE      = 16'h0100;
    localparam logic [15:0] DESC_CONFIG      = 16'h0200;
    localparam logic [15:0] DESC_STRING      = 16'h0300;
    localparam logic [15:0] DESC_STRING_END  = 16'(16'h0300 + STRING_COUNT);
    localparam logic [15:0] DESC_HID_REPORT  = 16'h2200;
    localparam logic [15:0] REPORT_IN_SEL    = 16'h0100;
    localparam logic [15:0] REPORT_OUT_SEL   = 16'h0200;
    localparam logic [15:0] ADDRESS_LIMIT    = 16'h0080;

    // ep0 actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_STALL     = 3'd1;
    localparam logic [2:0] ACT_TRANSMIT  = 3'd2;
    localparam logic [2:0] ACT_RECEIVE   = 3'd3;
    localparam logic [2:0] ACT_STALL_RX0 = 3'd4;
    localparam logic [2:0] ACT_OPEN_EP0  = 3'd5;

    // data sources
    localparam logic [3:0] SRC_NONE        = 4'd0;
    localparam logic [3:0] SRC_STATUS      = 4'd1;
    localparam logic [3:0] SRC_DEVICE      = 4'd2;
    localparam logic [3:0] SRC_CONFIG      = 4'd3;
    localparam logic [3:0] SRC_STRING      = 4'd4;
    localparam logic [3:0] SRC_REPORT_DESC = 4'd5;
    localparam logic [3:0] SRC_REPORT_IN   = 4'd6;
    localparam logic [3:0] SRC_IDLE        = 4'd7;
    localparam logic [3:0] SRC_PROTOCOL    = 4'd8;
    localparam logic [3:0] SRC_REPORT_OUT  = 4'd9;
    localparam logic [3:0] SRC_CONTINUE    = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_DESC_LEN = 2'd0;
    localparam logic [1:0] CFG_CONFIG_DESC_LEN = 2'd1;
    localparam logic [1:0] CFG_REPORT_DESC_LEN = 2'd2;
    localparam logic [1:0] CFG_STRING_LENGTHS  = 2'd3;

    localparam logic [7:0]  DEVICE_DESC_LEN_RST = 8'd18;
    localparam logic [15:0] CONFIG_DESC_LEN_RST = 16'd34;
    localparam logic [15:0] REPORT_DESC_LEN_RST = 16'd68;
    localparam logic [31:0] STRING_LENGTHS_RST  = 32'h1618_1204;
    localparam logic [7:0]  IDLE_DURATION_RST   = 8'd2;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_OUT      = 2'd1,
        MODE_IN       = 2'd2,
        MODE_IN_TRUNC = 2'd3
    } ep0_mode_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  endpoint;
        logic [7:0]  request_kind;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
    } hid_request_t;

    typedef struct packed {
        logic [2:0] ep0_action;
        logic       stall_in;
        logic [3:0] data_source;
        logic [1:0] string_number;
        logic [6:0] xfer_length;
        logic [7:0] reply_byte;
        logic       address_set;
        logic [6:0] device_address;
        logic       int_ep_open;
        logic       int_ep_close;
    } hid_result_t;

endpackage

// ===== hdl/usb_hid_control_endpoint_unit.sv =====
`timescale 1ns / 1ps

// Endpoint 0 request handler for a HID boot keyboard. Every input word is one
// event (setup packet, IN done, OUT done or bus reset) and produces exactly one
// result word telling the endpoint hardware what to do next: nothing, stall,
// transmit, receive, stall IN then receive a zero-length status, or reopen the
// control endpoints. Standard device requests, the interface get of the report
// descriptor and the HID class requests are decoded; anything else stalls in
// the direction given by bit 7 of bmRequestType. IN data longer than 64 bytes
// is sent in 64-byte packets, cut to wLength, with a zero-length end where the
// data is shorter than wLength and a whole number of packets long; each IN
// done on endpoint 0 in an IN data stage returns the next packet length, source "continue".
// Throughput is one word per clock while the result register is free: the event
// sits in an input register, is decoded against the control state in one pass
// of logic, and lands in a result register while the state updates in the same
// edge; m_valid is that register's valid bit. A result waiting on m_ready lets
// one word enter an empty input register, but a full one waits. The user must
// write the descriptor length registers through the cfg port while no event is
// in flight; the block does not enforce it. There is no clearing pass after reset.
module usb_hid_control_endpoint_unit (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  hidctl_pkg::hid_request_t  s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output hidctl_pkg::hid_result_t   m_data,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    // pipeline registers
    logic                     in_valid_reg;
    hidctl_pkg::hid_request_t in_item_reg;
    logic                     out_valid_reg;
    hidctl_pkg::hid_result_t  out_item_reg;

    // descriptor length registers
    logic [7:0]  device_desc_len_reg;
    logic [15:0] config_desc_len_reg;
    logic [15:0] report_desc_len_reg;
    logic [31:0] string_lengths_reg;

    // control state
    hidctl_pkg::ep0_mode_t ep0_mode_reg;
    hidctl_pkg::ep0_mode_t ep0_mode_next;
    logic [15:0]           in_left_reg;
    logic [15:0]           in_left_next;
    logic                  configured_reg;
    logic                  configured_next;
    logic [7:0]            idle_reg;
    logic [7:0]            idle_next;
    logic                  boot_proto_reg;
    logic                  boot_proto_next;

    hidctl_pkg::hid_result_t result_next;

    logic out_free;
    logic step;

    // setup decode
    logic [6:0]  kind_low;
    logic        setup_ok;
    logic        setup_rx;
    logic        setup_tx;
    logic [3:0]  dec_src;
    logic [15:0] dec_len;
    logic [1:0]  dec_str;
    logic [7:0]  dec_reply;
    logic        dec_addr_set;
    logic [6:0]  dec_addr;
    logic        dec_ep_open;
    logic        dec_ep_close;
    logic        dec_cfg_wr;
    logic        dec_idle_wr;
    logic        dec_proto_wr;

    // transfer start: clip to wLength, split off the first packet
    hidctl_pkg::ep0_mode_t si_mode;
    logic [15:0]           si_eff;
    logic [15:0]           si_left;
    logic [6:0]            si_xfer;

    // IN done helpers
    logic ep_zero;
    logic in_active;
    logic in_left_ge_mp;

    // handshakes: the result register frees when empty or taken
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    assign kind_low      = in_item_reg.request_kind[6:0];
    assign ep_zero       = (in_item_reg.endpoint == 4'd0);
    assign in_active     = (ep0_mode_reg == hidctl_pkg::MODE_IN) ||
                           (ep0_mode_reg == hidctl_pkg::MODE_IN_TRUNC);
    assign in_left_ge_mp = (in_left_reg >= hidctl_pkg::MAX_PACKET_W);
    assign setup_tx      = setup_ok && !setup_rx;

    // request decode for setup words
    always_comb begin
        setup_ok     = 1'b0;
        setup_rx     = 1'b0;
        dec_src      = hidctl_pkg::SRC_NONE;
        dec_len      = 16'd0;
        dec_str      = 2'd0;
        dec_reply    = 8'd0;
        dec_addr_set = 1'b0;
        dec_addr     = 7'd0;
        dec_ep_open  = 1'b0;
        dec_ep_close = 1'b0;
        dec_cfg_wr   = 1'b0;
        dec_idle_wr  = 1'b0;
        dec_proto_wr = 1'b0;
        unique case (kind_low)
            hidctl_pkg::RT_STD_DEVICE: begin
                unique case (in_item_reg.request_code)
                    hidctl_pkg::REQ_GET_STATUS: begin
                        if (in_item_reg.setup_length == 16'd2) begin
                            setup_ok = 1'b1;
                            dec_src  = hidctl_pkg::SRC_STATUS;
                            dec_len  = 16'd2;
                        end
                    end
                    hidctl_pkg::REQ_SET_ADDRESS: begin
                        if (in_item_reg.setup_index == 16'd0 &&
                            in_item_reg.setup_length == 16'd0 &&
                            in_item_reg.setup_value < hidctl_pkg::ADDRESS_LIMIT) begin
                            setup_ok     = 1'b1;
                            dec_addr_set = 1'b1;
                            dec_addr     = in_item_reg.setup_value[6:0];
                        end
                    end
                    hidctl_pkg::REQ_GET_DESCRIPTOR: begin
                        if (in_item_reg.setup_value == hidctl_pkg::DESC_DEVICE) begin
                            setup_ok = 1'b1;
                            dec_src  = hidctl_pkg::SRC_DEVICE;
                            dec_len  = {8'd0, device_desc_len_reg};
                        end else if (in_item_reg.setup_value == hidctl_pkg::DESC_CONFIG) begin
                            setup_ok = 1'b1;
                            dec_src  = hidctl_pkg::SRC_CONFIG;
                            dec_len  = config_desc_len_reg;
                        end else if (in_item_reg.setup_value >= hidctl_pkg::DESC_STRING &&
                                     in_item_reg.setup_value < hidctl_pkg::DESC_STRING_END) begin
                            setup_ok = 1'b1;
                            dec_src  = hidctl_pkg::SRC_STRING;
                            dec_str  = in_item_reg.setup_value[1:0];
                            dec_len  = {8'd0,
                                string_lengths_reg[{in_item_reg.setup_value[1:0], 3'b000} +: 8]};
                        end
                    end
                    hidctl_pkg::REQ_SET_CONFIGURATION: begin
                        if (in_item_reg.setup_value < 16'd2) begin
                            setup_ok   = 1'b1;
                            dec_cfg_wr = 1'b1;
                            // endpoint change only when the value really moves
                            if (in_item_reg.setup_value[0] != configured_reg) begin
                                dec_ep_open  = in_item_reg.setup_value[0];
                                dec_ep_close = !in_item_reg.setup_value[0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            hidctl_pkg::RT_STD_IFACE: begin
                if (configured_reg && in_item_reg.setup_index == 16'd0 &&
                    in_item_reg.request_code == hidctl_pkg::REQ_GET_DESCRIPTOR &&
                    in_item_reg.setup_value == hidctl_pkg::DESC_HID_REPORT) begin
                    setup_ok = 1'b1;
                    dec_src  = hidctl_pkg::SRC_REPORT_DESC;
                    dec_len  = report_desc_len_reg;
                end
            end
            hidctl_pkg::RT_CLASS_IFACE: begin
                if (configured_reg && in_item_reg.setup_index == 16'd0) begin
                    unique case (in_item_reg.request_code)
                        hidctl_pkg::HID_GET_REPORT: begin
                            if (in_item_reg.setup_value == hidctl_pkg::REPORT_IN_SEL &&
                                in_item_reg.setup_length <= hidctl_pkg::REPORT_BYTES_W) begin
                                setup_ok = 1'b1;
                                dec_src  = hidctl_pkg::SRC_REPORT_IN;
                                dec_len  = hidctl_pkg::REPORT_BYTES_W;
                            end
                        end
                        hidctl_pkg::HID_GET_IDLE: begin
                            if (in_item_reg.setup_length == 16'd1 &&
                                in_item_reg.setup_value == 16'd0) begin
                                setup_ok  = 1'b1;
                                dec_src   = hidctl_pkg::SRC_IDLE;
                                dec_len   = 16'd1;
                                dec_reply = idle_reg;
                            end
                        end
                        hidctl_pkg::HID_GET_PROTOCOL: begin
                            if (in_item_reg.setup_length == 16'd1 &&
                                in_item_reg.setup_value == 16'd0) begin
                                setup_ok  = 1'b1;
                                dec_src   = hidctl_pkg::SRC_PROTOCOL;
                                dec_len   = 16'd1;
                                dec_reply = {7'd0, boot_proto_reg};
                            end
                        end
                        hidctl_pkg::HID_SET_REPORT: begin
                            if (in_item_reg.setup_value == hidctl_pkg::REPORT_OUT_SEL &&
                                in_item_reg.setup_length <= hidctl_pkg::REPORT_BYTES_W) begin
                                setup_ok = 1'b1;
                                setup_rx = 1'b1;
                            end
                        end
                        hidctl_pkg::HID_SET_IDLE: begin
                            if (in_item_reg.setup_length == 16'd0 &&
                                in_item_reg.setup_value[7:0] == 8'd0) begin
                                setup_ok    = 1'b1;
                                dec_idle_wr = 1'b1;
                            end
                        end
                        hidctl_pkg::HID_SET_PROTOCOL: begin
                            if (in_item_reg.setup_length == 16'd0 &&
                                in_item_reg.setup_value < 16'd2) begin
                                setup_ok     = 1'b1;
                                dec_proto_wr = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // first packet of an IN data stage
    always_comb begin
        if (dec_len < in_item_reg.setup_length) begin
            si_eff  = dec_len;
            si_mode = (dec_len < hidctl_pkg::MAX_PACKET_W) ? hidctl_pkg::MODE_IDLE
                                                           : hidctl_pkg::MODE_IN_TRUNC;
        end else begin
            si_eff  = in_item_reg.setup_length;
            si_mode = (in_item_reg.setup_length <= hidctl_pkg::MAX_PACKET_W)
                      ? hidctl_pkg::MODE_IDLE : hidctl_pkg::MODE_IN;
        end
        if (si_eff > hidctl_pkg::MAX_PACKET_W) begin
            si_left = si_eff - hidctl_pkg::MAX_PACKET_W;
            si_xfer = hidctl_pkg::MAX_PACKET_X;
        end else begin
            si_left = 16'd0;
            si_xfer = si_eff[6:0];
        end
    end

    // ep0 mode next state
    always_comb begin
        ep0_mode_next = ep0_mode_reg;
        unique case (in_item_reg.req_type)
            hidctl_pkg::EV_SETUP: begin
                if (setup_tx) begin
                    ep0_mode_next = si_mode;
                end else if (setup_rx) begin
                    ep0_mode_next = hidctl_pkg::MODE_OUT;
                end
            end
            hidctl_pkg::EV_IN_DONE: begin
                if (ep_zero && in_active) begin
                    if (!in_left_ge_mp) begin
                        ep0_mode_next = hidctl_pkg::MODE_IDLE;
                    end else if (in_left_reg == hidctl_pkg::MAX_PACKET_W &&
                                 ep0_mode_reg != hidctl_pkg::MODE_IN_TRUNC) begin
                        // last full packet with no zero-length end owed
                        ep0_mode_next = hidctl_pkg::MODE_IDLE;
                    end
                end
            end
            hidctl_pkg::EV_OUT_DONE: begin
                if (ep_zero && ep0_mode_reg == hidctl_pkg::MODE_OUT) begin
                    ep0_mode_next = hidctl_pkg::MODE_IDLE;
                end
            end
            hidctl_pkg::EV_BUS_RESET: begin
                ep0_mode_next = hidctl_pkg::MODE_IDLE;
            end
        endcase
    end

    // result word and the rest of the control state
    always_comb begin
        result_next     = '0;
        in_left_next    = in_left_reg;
        configured_next = configured_reg;
        idle_next       = idle_reg;
        boot_proto_next = boot_proto_reg;
        unique case (in_item_reg.req_type)
            hidctl_pkg::EV_SETUP: begin
                if (!setup_ok) begin
                    // rejected request: stall, state untouched
                    result_next.ep0_action = hidctl_pkg::ACT_STALL;
                    result_next.stall_in   = in_item_reg.request_kind[7];
                end else if (setup_rx) begin
                    result_next.ep0_action  = hidctl_pkg::ACT_RECEIVE;
                    result_next.data_source = hidctl_pkg::SRC_REPORT_OUT;
                    result_next.xfer_length = in_item_reg.setup_length[6:0];
                end else begin
                    result_next.ep0_action     = hidctl_pkg::ACT_TRANSMIT;
                    result_next.data_source    = dec_src;
                    result_next.string_number  = dec_str;
                    result_next.xfer_length    = si_xfer;
                    result_next.reply_byte     = dec_reply;
                    result_next.address_set    = dec_addr_set;
                    result_next.device_address = dec_addr;
                    result_next.int_ep_open    = dec_ep_open;
                    result_next.int_ep_close   = dec_ep_close;
                    in_left_next               = si_left;
                    if (dec_cfg_wr) begin
                        configured_next = in_item_reg.setup_value[0];
                    end
                    if (dec_idle_wr) begin
                        idle_next = in_item_reg.setup_value[15:8];
                    end
                    if (dec_proto_wr) begin
                        boot_proto_next = in_item_reg.setup_value[0];
                    end
                end
            end
            hidctl_pkg::EV_IN_DONE: begin
                if (ep_zero) begin
                    if (in_active) begin
                        result_next.ep0_action  = hidctl_pkg::ACT_TRANSMIT;
                        result_next.data_source = hidctl_pkg::SRC_CONTINUE;
                        if (in_left_ge_mp) begin
                            in_left_next            = in_left_reg - hidctl_pkg::MAX_PACKET_W;
                            result_next.xfer_length = hidctl_pkg::MAX_PACKET_X;
                        end else begin
                            result_next.xfer_length = in_left_reg[6:0];
                        end
                    end else begin
                        // status stage IN with nothing pending
                        result_next.ep0_action = hidctl_pkg::ACT_STALL_RX0;
                    end
                end
            end
            hidctl_pkg::EV_OUT_DONE: begin
                if (ep_zero && ep0_mode_reg == hidctl_pkg::MODE_OUT) begin
                    result_next.ep0_action = hidctl_pkg::ACT_TRANSMIT;
                end
            end
            hidctl_pkg::EV_BUS_RESET: begin
                result_next.ep0_action = hidctl_pkg::ACT_OPEN_EP0;
                in_left_next           = 16'd0;
                configured_next        = 1'b0;
                idle_next              = hidctl_pkg::IDLE_DURATION_RST;
                boot_proto_next        = 1'b1;
            end
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_item_reg <= result_next;
        end
    end

    // control state, advanced together with the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep0_mode_reg   <= hidctl_pkg::MODE_IDLE;
            in_left_reg    <= 16'd0;
            configured_reg <= 1'b0;
            idle_reg       <= hidctl_pkg::IDLE_DURATION_RST;
            boot_proto_reg <= 1'b1;
        end else if (step) begin
            ep0_mode_reg   <= ep0_mode_next;
            in_left_reg    <= in_left_next;
            configured_reg <= configured_next;
            idle_reg       <= idle_next;
            boot_proto_reg <= boot_proto_next;
        end
    end

    // descriptor length registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_desc_len_reg <= hidctl_pkg::DEVICE_DESC_LEN_RST;
            config_desc_len_reg <= hidctl_pkg::CONFIG_DESC_LEN_RST;
            report_desc_len_reg <= hidctl_pkg::REPORT_DESC_LEN_RST;
            string_lengths_reg  <= hidctl_pkg::STRING_LENGTHS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hidctl_pkg::CFG_DEVICE_DESC_LEN: device_desc_len_reg <= cfg_data[7:0];
                hidctl_pkg::CFG_CONFIG_DESC_LEN: config_desc_len_reg <= cfg_data[15:0];
                hidctl_pkg::CFG_REPORT_DESC_LEN: report_desc_len_reg <= cfg_data[15:0];
                hidctl_pkg::CFG_STRING_LENGTHS:  string_lengths_reg  <= cfg_data;
            endcase
        end
    end

    // bus reset leaves the function unconfigured and ep0 idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_item_reg.req_type == hidctl_pkg::EV_BUS_RESET
        |=> !configured_reg && ep0_mode_reg == hidctl_pkg::MODE_IDLE && in_left_reg == 16'd0)
        else $error("bus reset did not clear control state");

    // a stalled setup must not disturb any control state
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && result_next.ep0_action == hidctl_pkg::ACT_STALL
        |=> $stable(ep0_mode_reg) && $stable(in_left_reg) && $stable(configured_reg) &&
            $stable(idle_reg) && $stable(boot_proto_reg))
        else $error("stalled request changed control state");

    // no packet longer than the endpoint size
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_item_reg.xfer_length <= hidctl_pkg::MAX_PACKET_X)
        else $error("packet length above max packet size");

    // interrupt endpoint is never opened and closed by the same word
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_item_reg.int_ep_open && out_item_reg.int_ep_close))
        else $error("interrupt endpoint opened and closed together");

    // a word in the input register moves on whenever the result register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("decoded word not registered");

endmodule
